// ===== src/mi3_pkg.sv =====
package mi3_pkg;

   localparam int Dim       = 3;
   localparam int NumElem   = Dim * Dim;
   localparam int ElemW     = 32;
   localparam int ProdW     = 2 * ElemW;
   localparam int CofW      = 65;
   localparam int MagW      = 64;
   localparam int DetW      = 97;
   localparam int DmagW     = 96;
   localparam int RemW      = DmagW + 1;
   localparam int RecipW    = 64;
   localparam int ShiftW    = 7;
   localparam int NormSteps = 7;
   localparam int DivSteps  = 62;
   localparam int ThrW      = 31;
   localparam int CsrDataW  = 32;
   localparam int CsrAddrW  = 3;

   // Register index, taken from the word address bit of the APB address.
   localparam logic CsrIdxDetMin = 1'b0;

   localparam logic [ThrW-1:0]   DetMinReset = ThrW'(1);
   localparam logic [ShiftW-1:0] DmagTop     = ShiftW'(DmagW - 1);

   typedef logic [NumElem-1:0][ElemW-1:0] elems_type;

   typedef struct packed {
      logic [NumElem-1:0]           neg;
      logic [NumElem-1:0][MagW-1:0] mag;
   } cofs_type;

   typedef struct packed {
      logic              valid;
      logic              singular;
      logic              dneg;
      logic [ShiftW-1:0] nm1;
      cofs_type          cofs;
   } item_type;

   typedef struct packed {
      logic               valid;
      logic               singular;
      logic [ShiftW-1:0]  nm1;
      logic [NumElem-1:0] neg;
   } scale_ctl_type;

endpackage

// ===== src/mi3_cofactor.sv =====
// Input register, the eighteen 2x2 minor products and the nine signed cofactors.
module mi3_cofactor (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            accept,
   input  mi3_pkg::elems_type                              elem,
   output logic                                            valid,
   output logic [mi3_pkg::Dim-1:0][mi3_pkg::ElemW-1:0]     col0,
   output logic [mi3_pkg::NumElem-1:0][mi3_pkg::CofW-1:0]  cof
);

   logic [2:0]                                           valid_ff;
   mi3_pkg::elems_type                                   elem_ff;
   logic [mi3_pkg::NumElem-1:0][mi3_pkg::ProdW-1:0]      p_ff, p_in, q_ff, q_in;
   logic [mi3_pkg::NumElem-1:0][mi3_pkg::CofW-1:0]       cof_ff, cof_in;
   logic [mi3_pkg::Dim-1:0][mi3_pkg::ElemW-1:0]          col0_p_ff, col0_c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[1:0], accept};
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         elem_ff <= elem;
      end
      p_ff   <= p_in;
      q_ff   <= q_in;
      cof_ff <= cof_in;
      for (int r = 0; r < mi3_pkg::Dim; r++) begin
         col0_p_ff[r] <= elem_ff[r * mi3_pkg::Dim];
         col0_c_ff[r] <= col0_p_ff[r];
      end
   end

   for (genvar k = 0; k < mi3_pkg::NumElem; k++) begin : g_minor
      localparam int Row = k / mi3_pkg::Dim;
      localparam int Col = k % mi3_pkg::Dim;
      localparam int R1  = (Row == 0) ? 1 : 0;
      localparam int R2  = (Row == 2) ? 1 : 2;
      localparam int C1  = (Col == 0) ? 1 : 0;
      localparam int C2  = (Col == 2) ? 1 : 2;
      localparam int Odd = (Row + Col) % 2;

      logic signed [mi3_pkg::ElemW-1:0] ea, eb, ec, ed;
      logic signed [mi3_pkg::ProdW-1:0] pa, pb;
      logic signed [mi3_pkg::CofW-1:0]  ps, qs;

      assign ea = elem_ff[R1 * mi3_pkg::Dim + C1];
      assign eb = elem_ff[R2 * mi3_pkg::Dim + C2];
      assign ec = elem_ff[R1 * mi3_pkg::Dim + C2];
      assign ed = elem_ff[R2 * mi3_pkg::Dim + C1];
      assign pa = ea * eb;
      assign pb = ec * ed;
      assign p_in[k] = pa;
      assign q_in[k] = pb;

      assign ps = $signed(p_ff[k]);
      assign qs = $signed(q_ff[k]);
      assign cof_in[k] = (Odd != 0) ? (qs - ps) : (ps - qs);
   end

   assign valid = valid_ff[2];
   assign col0  = col0_c_ff;
   assign cof   = cof_ff;

endmodule

// ===== src/mi3_det.sv =====
// Determinant by expansion down column 0, its magnitude, the singular test and
// a staged normalisation of the magnitude so that its top bit is set.
module mi3_det (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            valid,
   input  logic [mi3_pkg::Dim-1:0][mi3_pkg::ElemW-1:0]     col0,
   input  logic [mi3_pkg::NumElem-1:0][mi3_pkg::CofW-1:0]  cof,
   input  logic [mi3_pkg::ThrW-1:0]                        thr,
   output mi3_pkg::item_type                               item,
   output logic [mi3_pkg::DmagW-1:0]                       m
);

   localparam int HalfW = mi3_pkg::ElemW + 1;
   localparam int PpW   = mi3_pkg::ElemW + HalfW;

   logic [3:0]                                     v_ff;
   mi3_pkg::cofs_type                              cofs_in, cofs1_ff, cofs2_ff, cofs3_ff, cofs4_ff;
   logic [mi3_pkg::Dim-1:0][PpW-1:0]               pl_ff, pl_in, ph_ff, ph_in;
   logic [mi3_pkg::Dim-1:0][mi3_pkg::DetW-1:0]     term_ff, term_in;
   logic signed [mi3_pkg::DetW-1:0]                det_ff, det_in;
   logic [mi3_pkg::DetW-1:0]                       det_neg;
   logic [mi3_pkg::DmagW-1:0]                      dmag_ff, dmag_in, thr_ext;
   logic                                           dneg_ff;
   mi3_pkg::item_type                              first_item;

   mi3_pkg::item_type                              src_item [mi3_pkg::NormSteps];
   mi3_pkg::item_type                              nitem_ff [mi3_pkg::NormSteps];
   logic [mi3_pkg::NormSteps-1:0][mi3_pkg::DmagW-1:0]  src_m, nm_in, nm_ff;
   logic [mi3_pkg::NormSteps-1:0][mi3_pkg::ShiftW-1:0] src_s, ns_in, ns_ff;

   for (genvar k = 0; k < mi3_pkg::NumElem; k++) begin : g_mag
      logic [mi3_pkg::CofW-1:0] negc;
      assign negc = -cof[k];
      assign cofs_in.neg[k] = cof[k][mi3_pkg::CofW-1];
      assign cofs_in.mag[k] = cof[k][mi3_pkg::CofW-1] ? negc[mi3_pkg::MagW-1:0]
                                                       : cof[k][mi3_pkg::MagW-1:0];
   end

   for (genvar r = 0; r < mi3_pkg::Dim; r++) begin : g_term
      logic signed [mi3_pkg::ElemW-1:0] ev;
      logic signed [HalfW-1:0]          clo, chi;
      logic signed [PpW-1:0]            plo, phi;
      logic signed [mi3_pkg::DetW-1:0]  hs, ls;

      assign ev  = col0[r];
      assign clo = {1'b0, cof[r * mi3_pkg::Dim][mi3_pkg::ElemW-1:0]};
      assign chi = cof[r * mi3_pkg::Dim][mi3_pkg::CofW-1:mi3_pkg::ElemW];
      assign plo = ev * clo;
      assign phi = ev * chi;
      assign pl_in[r] = plo;
      assign ph_in[r] = phi;

      assign hs = {ph_ff[r], {mi3_pkg::ElemW{1'b0}}};
      assign ls = $signed(pl_ff[r]);
      assign term_in[r] = hs + ls;
   end

   assign det_in  = $signed(term_ff[0]) + $signed(term_ff[1]) + $signed(term_ff[2]);
   assign det_neg = -det_ff;
   assign dmag_in = det_ff[mi3_pkg::DetW-1] ? det_neg[mi3_pkg::DmagW-1:0]
                                            : det_ff[mi3_pkg::DmagW-1:0];

   // Threshold is Q16.16 against a Q48.48 determinant.
   assign thr_ext = mi3_pkg::DmagW'({thr, {mi3_pkg::ElemW{1'b0}}});

   always_comb begin
      first_item          = '0;
      first_item.valid    = v_ff[3];
      first_item.singular = (dmag_ff == '0) || (dmag_ff < thr_ext);
      first_item.dneg     = dneg_ff;
      first_item.cofs     = cofs4_ff;
   end

   for (genvar i = 0; i < mi3_pkg::NormSteps; i++) begin : g_norm
      localparam int Amt = 1 << (mi3_pkg::NormSteps - 1 - i);
      logic hi_zero;

      if (i == 0) begin : g_first
         assign src_item[i] = first_item;
         assign src_m[i]    = dmag_ff;
         assign src_s[i]    = '0;
      end else begin : g_rest
         assign src_item[i] = nitem_ff[i-1];
         assign src_m[i]    = nm_ff[i-1];
         assign src_s[i]    = ns_ff[i-1];
      end

      assign hi_zero = (src_m[i][mi3_pkg::DmagW-1 -: Amt] == '0);
      assign nm_in[i] = hi_zero ? (src_m[i] << Amt) : src_m[i];
      assign ns_in[i] = hi_zero ? (src_s[i] + mi3_pkg::ShiftW'(Amt)) : src_s[i];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[2:0], valid};
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < mi3_pkg::NormSteps; i++) begin
         if (reset) begin
            nitem_ff[i].valid <= 1'b0;
         end else begin
            nitem_ff[i] <= src_item[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      cofs1_ff <= cofs_in;
      pl_ff    <= pl_in;
      ph_ff    <= ph_in;
      cofs2_ff <= cofs1_ff;
      term_ff  <= term_in;
      cofs3_ff <= cofs2_ff;
      det_ff   <= det_in;
      cofs4_ff <= cofs3_ff;
      dmag_ff  <= dmag_in;
      dneg_ff  <= det_ff[mi3_pkg::DetW-1];
      nm_ff    <= nm_in;
      ns_ff    <= ns_in;
   end

   always_comb begin
      item     = nitem_ff[mi3_pkg::NormSteps-1];
      item.nm1 = mi3_pkg::DmagTop - ns_ff[mi3_pkg::NormSteps-1];
   end

   assign m = nm_ff[mi3_pkg::NormSteps-1];

endmodule

// ===== src/mi3_recip.sv =====
// Restoring division, one quotient bit per stage: recip = floor(2^158 / m)
// for a normalised divisor m, which equals floor(2^(n+62) / |D|).
module mi3_recip (
   input  logic                            clock,
   input  logic                            reset,
   input  mi3_pkg::item_type               item,
   input  logic [mi3_pkg::DmagW-1:0]       m,
   output mi3_pkg::item_type               item_out,
   output logic [mi3_pkg::RecipW-1:0]      recip
);

   localparam int Stages = mi3_pkg::DivSteps + 1;

   mi3_pkg::item_type                                src_item [Stages];
   mi3_pkg::item_type                                item_ff  [Stages];
   logic [Stages-1:0][mi3_pkg::RemW-1:0]             rem_in, rem_ff;
   logic [Stages-1:0][mi3_pkg::RecipW-1:0]           q_in, q_ff;
   logic [Stages-1:0][mi3_pkg::DmagW-1:0]            m_in, m_ff;

   for (genvar i = 0; i < Stages; i++) begin : g_stage
      if (i == 0) begin : g_first
         logic [mi3_pkg::RemW-1:0] pow, two_m, one_m;
         logic                     ge;
         assign pow   = {1'b1, {mi3_pkg::DmagW{1'b0}}};
         assign two_m = {m, 1'b0};
         assign one_m = {1'b0, m};
         assign ge    = (pow >= two_m);
         assign rem_in[i]   = ge ? (pow - two_m) : (pow - one_m);
         assign q_in[i]     = ge ? mi3_pkg::RecipW'(2) : mi3_pkg::RecipW'(1);
         assign m_in[i]     = m;
         assign src_item[i] = item;
      end else begin : g_step
         logic [mi3_pkg::RemW-1:0] rem2, div;
         logic                     ge;
         assign rem2 = {rem_ff[i-1][mi3_pkg::RemW-2:0], 1'b0};
         assign div  = {1'b0, m_ff[i-1]};
         assign ge   = (rem2 >= div);
         assign rem_in[i]   = ge ? (rem2 - div) : rem2;
         assign q_in[i]     = {q_ff[i-1][mi3_pkg::RecipW-2:0], ge};
         assign m_in[i]     = m_ff[i-1];
         assign src_item[i] = item_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < Stages; i++) begin
         if (reset) begin
            item_ff[i].valid <= 1'b0;
         end else begin
            item_ff[i] <= src_item[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      q_ff   <= q_in;
      m_ff   <= m_in;
   end

   assign item_out = item_ff[Stages-1];
   assign recip    = q_ff[Stages-1];

endmodule

// ===== src/mi3_scale.sv =====
// Transposed cofactors times the reciprocal, then rounding, saturation and sign.
module mi3_scale (
   input  logic                          clock,
   input  logic                          reset,
   input  mi3_pkg::item_type             item,
   input  logic [mi3_pkg::RecipW-1:0]    recip,
   output logic                          valid,
   output mi3_pkg::elems_type            elem,
   output logic                          singular
);

   localparam int HalfW = 32;
   localparam int PpW   = 2 * HalfW;
   localparam int XW    = 128;
   localparam int YW    = XW - 30;
   localparam logic [mi3_pkg::ElemW-1:0] PosMax = 32'h7FFF_FFFF;
   localparam logic [mi3_pkg::ElemW-1:0] NegMax = 32'h8000_0000;

   mi3_pkg::scale_ctl_type                               ctl_in, ctl1_ff, ctl2_ff, ctl3_ff, ctl4_ff;
   logic [mi3_pkg::NumElem-1:0][3:0][PpW-1:0]            pp_in, pp_ff;
   logic [mi3_pkg::NumElem-1:0][XW-1:0]                  x_in, x_ff;
   logic [mi3_pkg::NumElem-1:0][YW-1:0]                  y_in, y_ff, z_in, z_ff;
   mi3_pkg::elems_type                                   elem_in, elem_ff;
   logic                                                 valid_ff, singular_ff;

   always_comb begin
      ctl_in.valid    = item.valid;
      ctl_in.singular = item.singular;
      ctl_in.nm1      = item.nm1;
   end

   for (genvar j = 0; j < mi3_pkg::NumElem; j++) begin : g_elem
      localparam int Row = j / mi3_pkg::Dim;
      localparam int Col = j % mi3_pkg::Dim;
      localparam int K   = Col * mi3_pkg::Dim + Row;

      logic [HalfW-1:0]   a0, a1, b0, b1;
      logic [YW-1:0]      y;
      logic [YW:0]        rnd;
      logic [YW-1:0]      w;
      logic [mi3_pkg::ElemW-1:0] wneg;

      assign ctl_in.neg[j] = item.cofs.neg[K] ^ item.dneg;

      assign a0 = item.cofs.mag[K][HalfW-1:0];
      assign a1 = item.cofs.mag[K][mi3_pkg::MagW-1:HalfW];
      assign b0 = recip[HalfW-1:0];
      assign b1 = recip[mi3_pkg::RecipW-1:HalfW];
      assign pp_in[j][0] = a0 * b0;
      assign pp_in[j][1] = a0 * b1;
      assign pp_in[j][2] = a1 * b0;
      assign pp_in[j][3] = a1 * b1;

      assign x_in[j] = {pp_ff[j][3], {PpW{1'b0}}}
                     + {{HalfW{1'b0}}, pp_ff[j][1], {HalfW{1'b0}}}
                     + {{HalfW{1'b0}}, pp_ff[j][2], {HalfW{1'b0}}}
                     + {{PpW{1'b0}}, pp_ff[j][0]};

      // Shift right by n+29 in two steps; the final halving rounds.
      assign y       = x_ff[j][XW-1:XW-YW];
      assign y_in[j] = y >> {ctl2_ff.nm1[mi3_pkg::ShiftW-1:3], 3'b000};
      assign z_in[j] = y_ff[j] >> ctl3_ff.nm1[2:0];

      assign rnd  = {1'b0, z_ff[j]} + (YW + 1)'(1);
      assign w    = rnd[YW:1];
      assign wneg = -w[mi3_pkg::ElemW-1:0];

      always_comb begin
         if (ctl4_ff.singular) begin
            elem_in[j] = '0;
         end else if (ctl4_ff.neg[j]) begin
            elem_in[j] = (w > YW'(NegMax)) ? NegMax : wneg;
         end else begin
            elem_in[j] = (w > YW'(PosMax)) ? PosMax : w[mi3_pkg::ElemW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff.valid <= 1'b0;
         ctl2_ff.valid <= 1'b0;
         ctl3_ff.valid <= 1'b0;
         ctl4_ff.valid <= 1'b0;
         valid_ff      <= 1'b0;
      end else begin
         ctl1_ff  <= ctl_in;
         ctl2_ff  <= ctl1_ff;
         ctl3_ff  <= ctl2_ff;
         ctl4_ff  <= ctl3_ff;
         valid_ff <= ctl4_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      pp_ff       <= pp_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      z_ff        <= z_in;
      elem_ff     <= elem_in;
      singular_ff <= ctl4_ff.singular;
   end

   assign valid    = valid_ff;
   assign elem     = elem_ff;
   assign singular = singular_ff;

endmodule

// ===== src/matrix_inverse_3x3_top.sv =====
// 3x3 matrix inverse by the adjugate, signed Q16.16 in and out. A transaction
// is taken at every rising edge where start is high; busy is always low, so a
// new matrix may be offered in every cycle and the block sustains one matrix
// per clock. Its result appears with rsp_valid high for exactly one cycle and
// is taken at the edge that ends that cycle. On the way, the transaction
// passes through the 63 one-bit stages of the reciprocal divider plus 19
// stages of cofactor, determinant, normalisation and scaling logic. Results
// leave in the order the matrices came in. The receiver cannot stall the
// block, so it must be ready to capture a result in any cycle.
// A matrix whose determinant magnitude is zero or below det_min_magnitude
// (Q16.16, register at byte address 0) returns rsp_singular high and nine zero
// elements. Elements that overflow saturate to the signed 32-bit limits. Write
// det_min_magnitude only while no transaction is in flight.
module matrix_inverse_3x3_top (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              start,
   output logic                              busy,
   input  logic signed [31:0]                req_in_c0r0,
   input  logic signed [31:0]                req_in_c1r0,
   input  logic signed [31:0]                req_in_c2r0,
   input  logic signed [31:0]                req_in_c0r1,
   input  logic signed [31:0]                req_in_c1r1,
   input  logic signed [31:0]                req_in_c2r1,
   input  logic signed [31:0]                req_in_c0r2,
   input  logic signed [31:0]                req_in_c1r2,
   input  logic signed [31:0]                req_in_c2r2,

   output logic                              rsp_valid,
   output logic signed [31:0]                rsp_out_c0r0,
   output logic signed [31:0]                rsp_out_c1r0,
   output logic signed [31:0]                rsp_out_c2r0,
   output logic signed [31:0]                rsp_out_c0r1,
   output logic signed [31:0]                rsp_out_c1r1,
   output logic signed [31:0]                rsp_out_c2r1,
   output logic signed [31:0]                rsp_out_c0r2,
   output logic signed [31:0]                rsp_out_c1r2,
   output logic signed [31:0]                rsp_out_c2r2,
   output logic                              rsp_singular,

   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [mi3_pkg::CsrAddrW-1:0]      paddr,
   input  logic [mi3_pkg::CsrDataW-1:0]      pwdata,
   output logic [mi3_pkg::CsrDataW-1:0]      prdata,
   output logic                              pready
);

   // Configuration register. Bit 2 of the byte address selects the register;
   // the two low bits are ignored as the port only moves whole words.
   logic [mi3_pkg::ThrW-1:0] det_min_ff;
   logic                     csr_hit;
   logic                     csr_write;

   mi3_pkg::elems_type       req_elem;
   mi3_pkg::elems_type       rsp_elem;

   logic                                                   cof_valid;
   logic [mi3_pkg::Dim-1:0][mi3_pkg::ElemW-1:0]            cof_col0;
   logic [mi3_pkg::NumElem-1:0][mi3_pkg::CofW-1:0]         cof_value;
   mi3_pkg::item_type                                      det_item;
   logic [mi3_pkg::DmagW-1:0]                              det_m;
   mi3_pkg::item_type                                      recip_item;
   logic [mi3_pkg::RecipW-1:0]                             recip_value;

   assign pready    = 1'b1;
   assign csr_hit   = (paddr[2] == mi3_pkg::CsrIdxDetMin);
   assign csr_write = psel && penable && pwrite && pready && csr_hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         det_min_ff <= mi3_pkg::DetMinReset;
      end else if (csr_write) begin
         det_min_ff <= pwdata[mi3_pkg::ThrW-1:0];
      end
   end

   assign prdata = csr_hit ? mi3_pkg::CsrDataW'(det_min_ff) : '0;

   // The pipeline never stalls, so every offered transaction is taken.
   assign busy = 1'b0;

   // Element k is row k/3, column k%3, matching the port order.
   assign req_elem[0] = req_in_c0r0;
   assign req_elem[1] = req_in_c1r0;
   assign req_elem[2] = req_in_c2r0;
   assign req_elem[3] = req_in_c0r1;
   assign req_elem[4] = req_in_c1r1;
   assign req_elem[5] = req_in_c2r1;
   assign req_elem[6] = req_in_c0r2;
   assign req_elem[7] = req_in_c1r2;
   assign req_elem[8] = req_in_c2r2;

   // Three stages: input register, minor products, signed cofactors.
   mi3_cofactor u_cofactor (
      .clock  (clock),
      .reset  (reset),
      .accept (start && !busy),
      .elem   (req_elem),
      .valid  (cof_valid),
      .col0   (cof_col0),
      .cof    (cof_value)
   );

   // Eleven stages: determinant, magnitude, singular test and normalisation.
   mi3_det u_det (
      .clock (clock),
      .reset (reset),
      .valid (cof_valid),
      .col0  (cof_col0),
      .cof   (cof_value),
      .thr   (det_min_ff),
      .item  (det_item),
      .m     (det_m)
   );

   // Sixty-three stages of the reciprocal divider.
   mi3_recip u_recip (
      .clock    (clock),
      .reset    (reset),
      .item     (det_item),
      .m        (det_m),
      .item_out (recip_item),
      .recip    (recip_value)
   );

   // Five stages: partial products, sum, two shift steps, round and saturate.
   mi3_scale u_scale (
      .clock    (clock),
      .reset    (reset),
      .item     (recip_item),
      .recip    (recip_value),
      .valid    (rsp_valid),
      .elem     (rsp_elem),
      .singular (rsp_singular)
   );

   assign rsp_out_c0r0 = rsp_elem[0];
   assign rsp_out_c1r0 = rsp_elem[1];
   assign rsp_out_c2r0 = rsp_elem[2];
   assign rsp_out_c0r1 = rsp_elem[3];
   assign rsp_out_c1r1 = rsp_elem[4];
   assign rsp_out_c2r1 = rsp_elem[5];
   assign rsp_out_c0r2 = rsp_elem[6];
   assign rsp_out_c1r2 = rsp_elem[7];
   assign rsp_out_c2r2 = rsp_elem[8];

endmodule

// ===== src/mi3_checker.sv =====
// Port-level checks of latency, singular results and register read-back.
module mi3_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic                              rsp_valid,
   input logic [31:0]                       rsp_out_c0r0,
   input logic [31:0]                       rsp_out_c1r0,
   input logic [31:0]                       rsp_out_c2r0,
   input logic [31:0]                       rsp_out_c0r1,
   input logic [31:0]                       rsp_out_c1r1,
   input logic [31:0]                       rsp_out_c2r1,
   input logic [31:0]                       rsp_out_c0r2,
   input logic [31:0]                       rsp_out_c1r2,
   input logic [31:0]                       rsp_out_c2r2,
   input logic                              rsp_singular,
   input logic                              psel,
   input logic                              penable,
   input logic                              pwrite,
   input logic [mi3_pkg::CsrAddrW-1:0]      paddr,
   input logic [mi3_pkg::CsrDataW-1:0]      pwdata,
   input logic [mi3_pkg::CsrDataW-1:0]      prdata
);

   localparam int Latency = 82;

   a_latency : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##Latency rsp_valid)
      else $error("accepted transaction gave no result at the expected edge");

   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, Latency))
      else $error("result without a matching accepted transaction");

   a_singular_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_singular) |->
         (rsp_out_c0r0 == '0) && (rsp_out_c1r0 == '0) && (rsp_out_c2r0 == '0) &&
         (rsp_out_c0r1 == '0) && (rsp_out_c1r1 == '0) && (rsp_out_c2r1 == '0) &&
         (rsp_out_c0r2 == '0) && (rsp_out_c1r2 == '0) && (rsp_out_c2r2 == '0))
      else $error("singular result carries non-zero elements");

   a_readback : assert property (@(posedge clock) disable iff (reset)
      (psel && penable && pwrite && (paddr[2] == mi3_pkg::CsrIdxDetMin)) |=>
         ((paddr[2] != mi3_pkg::CsrIdxDetMin) ||
          (prdata == {1'b0, $past(pwdata[mi3_pkg::ThrW-1:0])})))
      else $error("threshold register does not read back the value written");

endmodule

bind matrix_inverse_3x3_top mi3_checker u_mi3_checker (.*);

// ===== dv/matrix_inverse_3x3_checker.sv =====
module matrix_inverse_3x3_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  logic [8:0][31:0] req_elems,
   input  logic             rsp_valid,
   input  logic [8:0][31:0] rsp_elems,
   input  logic             rsp_singular,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   input  logic             pready,
   output int               mismatches,
   output int               outstanding,
   output int               inverses_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [8:0][31:0] elems;
      logic             singular;
   } inverse_type;

   inverse_type       pending_inverses[$];
   logic     [30:0]   det_threshold;

   // Exact adjugate inverse: cofactors and determinant in wide signed
   // arithmetic, a normalised reciprocal, then rounding and saturation.
   function automatic inverse_type predict_inverse(input logic [8:0][31:0] m,
                                                   input logic [30:0] thr);
      logic signed [127:0] e[3][3];
      logic signed [127:0] cof[3][3];
      logic signed [127:0] det;
      logic        [191:0] dmag, recip, cmag, prod, limit;
      int                  n, r1, r2, c1, c2;
      bit                  dneg, neg;
      inverse_type         res;
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            e[r][c] = {{96{m[r*3+c][31]}}, m[r*3+c]};
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            r1 = (r == 0) ? 1 : 0;
            r2 = (r == 2) ? 1 : 2;
            c1 = (c == 0) ? 1 : 0;
            c2 = (c == 2) ? 1 : 2;
            cof[r][c] = e[r1][c1] * e[r2][c2] - e[r1][c2] * e[r2][c1];
            if (((r + c) % 2) != 0) cof[r][c] = -cof[r][c];
         end
      end
      det = e[0][0] * cof[0][0] + e[1][0] * cof[1][0] + e[2][0] * cof[2][0];
      dneg = det < 0;
      dmag = '0;
      dmag[127:0] = dneg ? -det : det;
      limit = {161'b0, thr} << 32;
      res.elems = '0;
      res.singular = 1'b1;
      if (dmag == 0 || dmag < limit) return res;
      res.singular = 1'b0;
      n = 0;
      for (int i = 0; i < 128; i++)
         if (dmag[i]) n = i + 1;
      recip = (192'(1) << (n + 62)) / dmag;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            neg = (cof[c][r] < 0) != dneg;
            cmag = '0;
            cmag[127:0] = (cof[c][r] < 0) ? -cof[c][r] : cof[c][r];
            prod = (cmag * recip + (192'(1) << (n + 29))) >> (n + 30);
            if (neg) begin
               if (prod > 192'h8000_0000) prod = 192'h8000_0000;
               res.elems[r*3+c] = -prod[31:0];
            end else begin
               if (prod > 192'h7FFF_FFFF) prod = 192'h7FFF_FFFF;
               res.elems[r*3+c] = prod[31:0];
            end
         end
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      mismatches++;
   endtask

   initial begin
      mismatches = 0;
      inverses_seen = 0;
      outstanding = 0;
   end

   always @(posedge clock) begin
      inverse_type want;
      if (reset) begin
         pending_inverses.delete();
         det_threshold <= 31'd1;
      end else begin
         if (psel && penable && pwrite && pready && paddr[2] == mi3_pkg::CsrIdxDetMin)
            det_threshold <= pwdata[30:0];
         if (start && !busy)
            pending_inverses.push_back(predict_inverse(req_elems, det_threshold));
         if (rsp_valid) begin
            inverses_seen++;
            if (pending_inverses.size() == 0) begin
               report_mismatch("result with no matrix outstanding");
            end else begin
               want = pending_inverses.pop_front();
               for (int i = 0; i < 9; i++)
                  if (rsp_elems[i] !== want.elems[i])
                     report_mismatch($sformatf("element c%0dr%0d got %h want %h",
                        i % 3, i / 3, rsp_elems[i], want.elems[i]));
               if (rsp_singular !== want.singular)
                  report_mismatch($sformatf("singular got %b want %b",
                     rsp_singular, want.singular));
            end
         end
      end
      outstanding = pending_inverses.size();
   end

endmodule

// ===== dv/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int One = 65536;     // 1.0 in Q16.16
   localparam int Latency = 90;    // drain wait, longer than the block's pipeline

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   logic [8:0][31:0] req_elems = '0;
   logic [8:0][31:0] rsp_elems;
   logic             rsp_valid, rsp_singular;
   logic             psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [2:0]       paddr = '0;
   logic [31:0]      pwdata = '0;
   logic [31:0]      prdata;
   logic             pready;
   int               mismatches, outstanding, inverses_seen;
   int               matrices_sent = 0;
   int               settings_used = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   matrix_inverse_3x3_top dut (
      .clock, .reset, .start, .busy,
      .req_in_c0r0(req_elems[0]), .req_in_c1r0(req_elems[1]), .req_in_c2r0(req_elems[2]),
      .req_in_c0r1(req_elems[3]), .req_in_c1r1(req_elems[4]), .req_in_c2r1(req_elems[5]),
      .req_in_c0r2(req_elems[6]), .req_in_c1r2(req_elems[7]), .req_in_c2r2(req_elems[8]),
      .rsp_valid,
      .rsp_out_c0r0(rsp_elems[0]), .rsp_out_c1r0(rsp_elems[1]), .rsp_out_c2r0(rsp_elems[2]),
      .rsp_out_c0r1(rsp_elems[3]), .rsp_out_c1r1(rsp_elems[4]), .rsp_out_c2r1(rsp_elems[5]),
      .rsp_out_c0r2(rsp_elems[6]), .rsp_out_c1r2(rsp_elems[7]), .rsp_out_c2r2(rsp_elems[8]),
      .rsp_singular,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   // The checker watches both channels and the register port on its own; this
   // module only makes the stimulus and gives the verdict.
   matrix_inverse_3x3_checker checker_i (
      .clock, .reset, .start, .busy, .req_elems, .rsp_valid, .rsp_elems, .rsp_singular,
      .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
      .mismatches, .outstanding, .inverses_seen
   );

   // Offers one matrix and holds it until the block takes the transaction,
   // then idles for the requested number of cycles. With no gap, start simply
   // stays high for the next matrix, so it is never lowered and raised in the
   // same step.
   task automatic send_matrix(input logic [8:0][31:0] m, input int gap);
      start <= 1'b1;
      req_elems <= m;
      do @(posedge clock); while (busy);
      matrices_sent++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Setup then access phase; the register takes the value at the access edge.
   // Only called with the block drained, so no transaction sees a half-way
   // threshold. An edge with start low comes first, so that the last
   // transaction is already counted as outstanding before the wait.
   task automatic write_threshold(input logic [30:0] value);
      start <= 1'b0;
      @(posedge clock);
      wait (outstanding == 0);
      @(posedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      paddr <= 3'(mi3_pkg::CsrIdxDetMin) << 2;
      pwdata <= {1'b0, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      settings_used++;
   endtask

   // Diagonal matrix diag(a, b, c); for a = b = 1.0 the determinant is c scaled to Q48.48,
   // so c set just at or just below the threshold probes the singular boundary.
   function automatic logic [8:0][31:0] diag_matrix(input logic [31:0] a,
                                                     input logic [31:0] b,
                                                     input logic [31:0] c);
      logic [8:0][31:0] m;
      m = '0;
      m[0] = a;
      m[4] = b;
      m[8] = c;
      return m;
   endfunction

   // Random matrix of one of several shapes: full-range noise, well-scaled
   // values of a few units, a diagonally dominant matrix, a rank-deficient one
   // made by copying a row, and tiny elements that land near the threshold.
   function automatic logic [8:0][31:0] random_matrix();
      logic [8:0][31:0] m;
      int               shape;
      int               src, dst;
      shape = $urandom_range(0, 9);
      for (int i = 0; i < 9; i++) begin
         case (shape)
            0, 1: begin
               m[i] = $urandom();
            end
            2, 3, 4: begin
               m[i] = 32'($signed($urandom_range(0, 8 * One)) - 4 * One);
            end
            5, 6: begin
               m[i] = 32'($signed($urandom_range(0, One)) - One / 2);
               if (i % 4 == 0) m[i] = m[i] + 32'($urandom_range(2, 200) * One);
            end
            7: begin
               m[i] = 32'($signed($urandom_range(0, 512)) - 256);
            end
            default: begin
               m[i] = 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
            end
         endcase
      end
      if (shape == 9 || shape == 8 && $urandom_range(0, 1) == 1) begin
         src = $urandom_range(0, 2);
         dst = (src + $urandom_range(1, 2)) % 3;
         for (int c = 0; c < 3; c++) m[dst*3+c] = m[src*3+c];
      end
      return m;
   endfunction

   // Mostly random gaps, with whole stretches at full rate.
   function automatic int draw_gap(input bit full_rate);
      return full_rate ? 0 : $urandom_range(0, 8);
   endfunction

   initial begin
      logic [30:0] thr;
      bit          full_rate;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part under the reset threshold: identity, zero matrix, the
      // element extremes, saturation of a tiny determinant, a negative
      // determinant and both sides of the singular boundary.
      send_matrix(diag_matrix(One, One, One), 0);
      send_matrix('0, 1);
      send_matrix({9{32'h7FFF_FFFF}}, 0);
      send_matrix({9{32'h8000_0000}}, 2);
      send_matrix(diag_matrix(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF), 0);
      send_matrix(diag_matrix(32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 0);
      send_matrix(diag_matrix(1, 1, 1), 3);
      send_matrix(diag_matrix(One, One, 1), 0);
      send_matrix(diag_matrix(One, One, 0), 0);
      send_matrix(diag_matrix(One, 1, 1), 0);
      send_matrix(diag_matrix(-One, One, One), 4);
      send_matrix(diag_matrix(2 * One, -3 * One, 5 * One), 0);
      send_matrix({32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                   32'h0000_0000, 32'h0001_0000, 32'h0004_0000,
                   32'h0005_0000, 32'h0006_0000, 32'h0000_0000}, 0);
      send_matrix({32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001,
                   32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF}, 1);
      send_matrix({32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000,
                   32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000,
                   32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF}, 0);

      // Threshold zero: only an exactly zero determinant is still singular.
      write_threshold(31'd0);
      send_matrix('0, 0);
      send_matrix(diag_matrix(1, 1, 1), 0);
      send_matrix(diag_matrix(One, One, 1), 2);

      // Largest threshold: almost everything is singular apart from a huge
      // determinant.
      write_threshold(31'h7FFF_FFFF);
      send_matrix(diag_matrix(One, One, 32'h7FFF_FFFF), 0);
      send_matrix(diag_matrix(One, One, 32'h7FFF_FFFE), 0);
      send_matrix(diag_matrix(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 1);
      send_matrix(diag_matrix(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000), 0);

      // Random part in eight phases, each under its own threshold, with the
      // boundary probed on both sides at the start of every phase.
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: thr = 31'd1;
            1: thr = 31'(One);
            2: thr = 31'h7FFF_FFFF;
            3: thr = 31'd0;
            default: thr = 31'($urandom_range(0, 1 << ($urandom_range(0, 30))));
         endcase
         write_threshold(thr);
         send_matrix(diag_matrix(One, One, {1'b0, thr}), 0);
         send_matrix(diag_matrix(One, One, {1'b0, thr} - 1), 0);
         full_rate = 1'b0;
         for (int k = 0; k < 210; k++) begin
            if (k % 30 == 0) full_rate = $urandom_range(0, 2) == 0;
            // Once, let the pipeline run completely dry before going on.
            if (phase == 4 && k == 100) begin
               start <= 1'b0;
               @(posedge clock);
               wait (outstanding == 0);
               @(posedge clock);
            end
            send_matrix(random_matrix(), draw_gap(full_rate));
         end
      end

      start <= 1'b0;
      @(posedge clock);
      wait (outstanding == 0);
      repeat (Latency) @(posedge clock);
      $display("Covered %0d matrices and %0d results under %0d threshold settings,",
               matrices_sent, inverses_seen, settings_used + 1);
      $display("including singular, saturating and full-rate back-to-back traffic.");
      if (mismatches == 0 && outstanding == 0) begin
         $display("matrix_inverse_3x3_top regression: pass");
      end else begin
         $display("matrix_inverse_3x3_top regression: fail");
      end
      $finish;
   end

   // Watchdog: fails the run if it has not finished in time.
   initial begin
      #2ms;
      $display("matrix_inverse_3x3_top regression: fail");
      $finish;
   end

endmodule
